[rtl/core/ssc_pkg.sv]
// Shared types and constants for the speech segment coalescer.
// No dependencies; every other file in rtl/core imports this package.
package ssc_pkg;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned CFG_INDEX_W = 3;

    typedef logic [TIME_W-1:0] time_t;

    // Operation codes of an input request
    localparam logic OP_SEGMENT = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_MERGE_GAP     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_PIECE     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COMPACT_GAP   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_START  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_END_EN = 3'd5;

    // Reset values, in samples at 48 kHz
    localparam time_t MERGE_GAP_RESET   = 32'd38400;
    localparam time_t MIN_PIECE_RESET   = 32'd14400;
    localparam time_t COMPACT_GAP_RESET = 32'd48000;

    typedef struct packed {
        logic  operation;
        time_t segment_start;
        time_t segment_end;
    } ssc_in_t;

    typedef struct packed {
        time_t compact_position;
        time_t piece_start;
        time_t piece_length;
    } ssc_out_t;

    typedef struct packed {
        time_t merge_gap_samples;
        time_t min_piece_samples;
        time_t compact_gap_samples;
        time_t window_start;
        time_t window_end;
        logic  window_end_enabled;
    } ssc_cfg_t;

    // Result handed from the coalescing stage to the output register
    typedef struct packed {
        logic     valid;
        ssc_out_t data;
    } ssc_res_t;

endpackage

[rtl/core/ssc_cfg_regs.sv]
// Configuration register file of the speech segment coalescer.
// Depends on ssc_pkg for the register indexes and the ssc_cfg_t bundle.
module ssc_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::TIME_W-1:0]       cfg_data,
    output ssc_pkg::ssc_cfg_t                cfg
);
    import ssc_pkg::*;

    ssc_cfg_t cfg_reg;
    ssc_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                REG_MERGE_GAP:     cfg_next.merge_gap_samples   = cfg_data;
                REG_MIN_PIECE:     cfg_next.min_piece_samples   = cfg_data;
                REG_COMPACT_GAP:   cfg_next.compact_gap_samples = cfg_data;
                REG_WINDOW_START:  cfg_next.window_start        = cfg_data;
                REG_WINDOW_END:    cfg_next.window_end          = cfg_data;
                REG_WINDOW_END_EN: cfg_next.window_end_enabled  = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.merge_gap_samples   <= MERGE_GAP_RESET;
            cfg_reg.min_piece_samples   <= MIN_PIECE_RESET;
            cfg_reg.compact_gap_samples <= COMPACT_GAP_RESET;
            cfg_reg.window_start        <= '0;
            cfg_reg.window_end          <= '0;
            cfg_reg.window_end_enabled  <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/core/ssc_core.sv]
// Input register, pending-piece state and coalescing logic.
// Depends on ssc_pkg; feeds any result of a request to ssc_out_reg.
module ssc_core (
    input  logic              clk,
    input  logic              rst_n,
    input  ssc_pkg::ssc_cfg_t cfg,
    input  logic              in_valid,
    output logic              in_stall,
    input  ssc_pkg::ssc_in_t  in_data,
    input  logic              res_ready,
    output ssc_pkg::ssc_res_t res
);
    import ssc_pkg::*;

    logic    s1_valid_reg, s1_valid_next;
    ssc_in_t s1_data_reg;

    logic    pend_valid_reg, pend_valid_next;
    time_t   pend_start_reg, pend_start_next;
    time_t   pend_end_reg, pend_end_next;
    time_t   cursor_reg, cursor_next;

    logic    fire;
    logic    accept;
    logic    is_flush;
    logic    skip;
    logic    merge;
    logic    emit_ok;
    logic    emit;
    time_t   seg_start;
    time_t   seg_end;
    time_t   piece_len;
    logic [TIME_W+1:0] cursor_sum;
    time_t   cursor_adv;

    assign fire     = s1_valid_reg && res_ready;
    assign in_stall = s1_valid_reg && !res_ready;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
            s1_valid_next = 1'b1;
        else if (fire)
            s1_valid_next = 1'b0;
    end

    // Clip the request to the window
    assign is_flush  = (s1_data_reg.operation == OP_FLUSH);
    assign skip      = (s1_data_reg.segment_end <= cfg.window_start)
                    || (cfg.window_end_enabled
                        && s1_data_reg.segment_start >= cfg.window_end);
    assign seg_start = (s1_data_reg.segment_start < cfg.window_start)
                     ? cfg.window_start : s1_data_reg.segment_start;
    assign seg_end   = (cfg.window_end_enabled && s1_data_reg.segment_end > cfg.window_end)
                     ? cfg.window_end : s1_data_reg.segment_end;

    // Overlap always joins; otherwise join when the gap is short enough
    assign merge = pend_valid_reg
                && ((seg_start < pend_end_reg)
                    || ((seg_start - pend_end_reg) < cfg.merge_gap_samples));

    // Reversed pieces are never emitted
    assign piece_len = pend_end_reg - pend_start_reg;
    assign emit_ok   = pend_valid_reg && (pend_end_reg >= pend_start_reg)
                    && (piece_len >= cfg.min_piece_samples);

    assign cursor_sum = {2'b00, cursor_reg} + {2'b00, piece_len}
                      + {2'b00, cfg.compact_gap_samples};
    assign cursor_adv = (cursor_sum[TIME_W+1:TIME_W] != 2'b00)
                      ? {TIME_W{1'b1}} : cursor_sum[TIME_W-1:0];

    always_comb
    begin
        emit            = 1'b0;
        pend_valid_next = pend_valid_reg;
        pend_start_next = pend_start_reg;
        pend_end_next   = pend_end_reg;
        cursor_next     = cursor_reg;
        if (fire)
        begin
            if (is_flush)
            begin
                emit            = emit_ok;
                pend_valid_next = 1'b0;
                pend_start_next = '0;
                pend_end_next   = '0;
                cursor_next     = '0;
            end
            else if (skip)
            begin
                emit = 1'b0;
            end
            else if (merge)
            begin
                if (seg_end > pend_end_reg)
                    pend_end_next = seg_end;
            end
            else
            begin
                emit            = emit_ok;
                pend_valid_next = 1'b1;
                pend_start_next = seg_start;
                pend_end_next   = seg_end;
                if (emit_ok)
                    cursor_next = cursor_adv;
            end
        end
    end

    always_comb
    begin
        res.valid                 = emit;
        res.data.compact_position = cursor_reg;
        res.data.piece_start      = pend_start_reg;
        res.data.piece_length     = piece_len;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_start_reg <= '0;
            pend_end_reg   <= '0;
            cursor_reg     <= '0;
        end
        else
        begin
            s1_valid_reg   <= s1_valid_next;
            pend_valid_reg <= pend_valid_next;
            pend_start_reg <= pend_start_next;
            pend_end_reg   <= pend_end_next;
            cursor_reg     <= cursor_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            s1_data_reg <= in_data;
    end

endmodule

[rtl/core/ssc_out_reg.sv]
// Result register on the output channel of the speech segment coalescer.
// Depends on ssc_pkg for ssc_res_t and ssc_out_t.
module ssc_out_reg (
    input  logic               clk,
    input  logic               rst_n,
    input  ssc_pkg::ssc_res_t  res,
    input  logic               res_load,
    output logic               res_ready,
    output logic               out_valid,
    input  logic               out_stall,
    output ssc_pkg::ssc_out_t  out_data
);
    import ssc_pkg::*;

    logic     valid_reg, valid_next;
    ssc_out_t data_reg;

    // Free when empty or when the held result leaves this cycle
    assign res_ready = !valid_reg || !out_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (res_load)
            valid_next = res.valid;
        else if (!out_stall)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load && res.valid)
            data_reg <= res.data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[rtl/core/speech_segment_coalescer.sv]
// Speech segment coalescer: takes time-ordered speech segments (start and
// exclusive end sample), clips them to a window, joins close ones and emits
// finished pieces with their place in a compacted timeline. A request can be
// taken every cycle. It is held in an input register, and at the next edge at
// which the result register is free the coalescing logic updates the pending
// piece and loads any result into the result register, which presents it.
// Throughput is one request per cycle, set by the pending-piece state loop;
// the input stalls only while a request is held behind a result that the
// receiver is stalling. Configuration writes take effect on the next cycle and
// belong between tracks, while nothing is in flight.
module speech_segment_coalescer (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [ssc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [ssc_pkg::TIME_W-1:0]       cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  ssc_pkg::ssc_in_t                 in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output ssc_pkg::ssc_out_t                out_data
);
    import ssc_pkg::*;

    ssc_cfg_t cfg;
    ssc_res_t res;
    logic     res_ready;
    logic     res_load;
    logic     core_busy;
    logic     busy_reg, busy_next;

    ssc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ssc_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .res_ready (res_ready),
        .res       (res)
    );

    // The core processes its held request whenever the output side is free
    assign res_load = !in_stall && res_ready && core_busy;

    always_comb
    begin
        busy_next = busy_reg;
        if (in_valid && !in_stall)
            busy_next = 1'b1;
        else if (res_ready)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    assign core_busy = busy_reg;

    ssc_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .res       (res),
        .res_load  (res_load),
        .res_ready (res_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
